// ===== design/lpht_pkg.sv =====
// Shared types and constants of the linear probing hash table.
`default_nettype none
package lpht_pkg;

    // Fixed field widths
    localparam int KEY_W = 31;
    localparam int CFG_W = 7;
    localparam int ST_W  = 2;
    localparam int CMD_W = 2;

    // Entry limit after reset
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd48;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_PCHK,
        S_RM_RD,
        S_RM_CHK,
        S_RM_FIN,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== design/lpht_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/lpht_mod.sv =====
// Home slot unit: key modulo table capacity, a mask for a power of two, else a reciprocal multiply.
`default_nettype none
module lpht_mod #(
    parameter int CAPACITY = 64,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [lpht_pkg::KEY_W-1:0] i_key,
    output logic                          o_done,
    output logic      [IDX_W-1:0]         o_rem
);

    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_rem;

            // Remainder is the low key bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_key[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_recip
            localparam int KEY_W = lpht_pkg::KEY_W;
            localparam int PRD_W = KEY_W + 32;
            // floor(2^32 / CAPACITY): the quotient estimate is low by at most one
            localparam longint unsigned RECIP_L = (64'd1 << 32) / CAPACITY;
            localparam logic [31:0]      RECIP = 32'(RECIP_L);
            localparam logic [KEY_W-1:0] CAP_K = KEY_W'(CAPACITY);

            logic [2:0]       r_stage;
            logic             r_done;
            logic [KEY_W-1:0] r_key;
            logic [KEY_W-1:0] r_quot;
            logic [KEY_W-1:0] r_part;
            logic [IDX_W-1:0] r_rem;
            logic [PRD_W-1:0] prod;
            logic [KEY_W-1:0] qd;
            logic [KEY_W-1:0] part_fix;

            // Estimate quotient, back-multiply, one correcting subtract
            always_comb begin
                prod     = PRD_W'(r_key) * PRD_W'(RECIP);
                qd       = r_quot * CAP_K;
                part_fix = (r_part >= CAP_K) ? r_part - CAP_K : r_part;
            end

            // Stage valids; done rises with the remainder, after the key, quotient and partial registers
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= '0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= {r_stage[1:0], i_start};
                    r_done  <= r_stage[2];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                end
                if (r_stage[0]) begin
                    r_quot <= prod[PRD_W-1:32];
                end
                if (r_stage[1]) begin
                    r_part <= r_key - qd;
                end
                if (r_stage[2]) begin
                    r_rem <= part_fix[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table_top.sv =====
// Top level of the linear probing hash table: sequencer, entry RAM and result register.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_ready    i_command, i_key, i_value
//  out      from block o_out_valid / i_out_ready  o_status, o_found_value, o_entry_count
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_data (entry limit)
//
// One command at a time. Home slot: a mask for a power-of-two capacity, a reciprocal multiply otherwise.
// Find/insert: after the home slot, one RAM read per probed slot until a hit, an empty slot or the last slot.
// Remove then checks each later chain slot for backward shift and empties the final hole. Clear writes every slot.
// After reset a clearing pass writes every slot with o_in_ready low.
// A result waiting on i_out_ready holds the next command in its final cycle only.
`default_nettype none
module linear_probe_hash_table_top #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lpht_pkg::CMD_W-1:0]    i_command,
    input  wire logic [lpht_pkg::KEY_W-1:0]    i_key,
    input  wire logic [VALUE_BITS-1:0]         i_value,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [lpht_pkg::ST_W-1:0]     o_status,
    output logic      [VALUE_BITS-1:0]         o_found_value,
    output logic      [CNT_W-1:0]              o_entry_count,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpht_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int KEY_W = lpht_pkg::KEY_W;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = 1 + IDX_W + KEY_W + VALUE_BITS;
    localparam int CMP_W = (CNT_W > lpht_pkg::CFG_W) ? CNT_W : lpht_pkg::CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    // Control registers
    lpht_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [lpht_pkg::CFG_W-1:0] r_max;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    lpht_pkg::t_cmd    r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IDX_W-1:0]  r_home, n_home;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_hole, n_hole;
    logic [IDX_W-1:0]  r_cur, n_cur;
    lpht_pkg::t_status r_res_status, n_res_status;
    logic [VALUE_BITS-1:0] r_res_found, n_res_found;
    lpht_pkg::t_status r_status, n_status;
    logic [VALUE_BITS-1:0] r_found, n_found;
    logic [CNT_W-1:0]  r_entry, n_entry;

    // RAM and home slot unit
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic              mod_start, mod_done;
    logic [IDX_W-1:0]  mod_rem;

    // Entry fields of the read word
    logic              ent_valid;
    logic [IDX_W-1:0]  ent_home;
    logic [KEY_W-1:0]  ent_key;
    logic [VALUE_BITS-1:0] ent_val;

    logic              in_fire, out_free;
    logic [IDX_W-1:0]  pos_inc, cur_inc;
    logic              hit, empty, last, resolved, full, move;

    lpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lpht_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign ent_valid = ram_rdata[ENT_W-1];
    assign ent_home  = ram_rdata[VALUE_BITS+KEY_W +: IDX_W];
    assign ent_key   = ram_rdata[VALUE_BITS +: KEY_W];
    assign ent_val   = ram_rdata[VALUE_BITS-1:0];

    assign o_in_ready  = (r_state == lpht_pkg::S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Slot arithmetic and probe decisions
    always_comb begin
        pos_inc  = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
        cur_inc  = (r_cur == LAST_IDX) ? '0 : r_cur + 1'b1;
        hit      = ent_valid && (ent_key == r_key);
        empty    = !ent_valid;
        last     = (r_cnt == LAST_IDX);
        resolved = hit || empty || last;
        full     = (CMP_W'(r_count) >= CMP_W'(r_max)) || (r_count >= CAP_CNT);
        // backward shift: entry at cur may fill the hole
        if (r_cur > r_hole) begin
            move = (ent_home <= r_hole) || (ent_home > r_cur);
        end else begin
            move = (ent_home <= r_hole) && (ent_home > r_cur);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpht_pkg::S_INIT: begin
                if (r_pos == LAST_IDX) n_state = lpht_pkg::S_IDLE;
            end
            lpht_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = (lpht_pkg::t_cmd'(i_command) == lpht_pkg::CMD_CLEAR)
                            ? lpht_pkg::S_CLEAR : lpht_pkg::S_HASH;
                end
            end
            lpht_pkg::S_HASH: begin
                if (mod_done) n_state = lpht_pkg::S_PROBE;
            end
            lpht_pkg::S_PROBE: n_state = lpht_pkg::S_PCHK;
            lpht_pkg::S_PCHK: begin
                if (resolved) begin
                    n_state = (r_cmd == lpht_pkg::CMD_REMOVE && hit)
                            ? lpht_pkg::S_RM_RD : lpht_pkg::S_DONE;
                end
            end
            lpht_pkg::S_RM_RD: n_state = lpht_pkg::S_RM_CHK;
            lpht_pkg::S_RM_CHK: begin
                n_state = (!ent_valid || last) ? lpht_pkg::S_RM_FIN : lpht_pkg::S_RM_RD;
            end
            lpht_pkg::S_RM_FIN: n_state = lpht_pkg::S_DONE;
            lpht_pkg::S_CLEAR: begin
                if (r_pos == LAST_IDX) n_state = lpht_pkg::S_DONE;
            end
            lpht_pkg::S_DONE: begin
                if (out_free) n_state = lpht_pkg::S_IDLE;
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_pos        = r_pos;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_home       = r_home;
        n_cnt        = r_cnt;
        n_hole       = r_hole;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_status     = r_status;
        n_found      = r_found;
        n_entry      = r_entry;
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_pos;
        mod_start    = 1'b0;

        unique case (r_state)
            lpht_pkg::S_INIT: begin
                ram_we = 1'b1;
                n_pos  = pos_inc;
            end
            lpht_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_cmd     = lpht_pkg::t_cmd'(i_command);
                    n_key     = i_key;
                    n_val     = i_value;
                    n_pos     = '0;
                    mod_start = (lpht_pkg::t_cmd'(i_command) != lpht_pkg::CMD_CLEAR);
                end
            end
            lpht_pkg::S_HASH: begin
                if (mod_done) begin
                    n_home = mod_rem;
                    n_pos  = mod_rem;
                    n_cnt  = '0;
                end
            end
            lpht_pkg::S_PROBE: begin
                ram_re = 1'b1;
            end
            lpht_pkg::S_PCHK: begin
                if (!resolved) begin
                    // next slot of the chain, one read per cycle
                    n_pos     = pos_inc;
                    n_cnt     = r_cnt + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = pos_inc;
                end else begin
                    n_res_found = '0;
                    unique case (r_cmd)
                        lpht_pkg::CMD_FIND: begin
                            if (hit) begin
                                n_res_status = lpht_pkg::ST_OK;
                                n_res_found  = ent_val;
                            end else begin
                                n_res_status = lpht_pkg::ST_NOT_FOUND;
                            end
                        end
                        lpht_pkg::CMD_INSERT: begin
                            if (hit) begin
                                ram_we       = 1'b1;
                                ram_wdata    = {1'b1, ent_home, ent_key, r_val};
                                n_res_status = lpht_pkg::ST_OK;
                            end else if (full || !empty) begin
                                n_res_status = lpht_pkg::ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                ram_wdata    = {1'b1, r_home, r_key, r_val};
                                n_count      = r_count + 1'b1;
                                n_res_status = lpht_pkg::ST_OK;
                            end
                        end
                        lpht_pkg::CMD_REMOVE: begin
                            if (hit) begin
                                n_hole       = r_pos;
                                n_cur        = r_pos;
                                n_cnt        = '0;
                                n_res_status = lpht_pkg::ST_OK;
                            end else begin
                                n_res_status = lpht_pkg::ST_NOT_FOUND;
                            end
                        end
                        lpht_pkg::CMD_CLEAR: begin
                            n_res_status = lpht_pkg::ST_OK;
                        end
                    endcase
                end
            end
            lpht_pkg::S_RM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cur_inc;
                n_cur     = cur_inc;
            end
            lpht_pkg::S_RM_CHK: begin
                if (ent_valid) begin
                    if (move) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hole;
                        ram_wdata = ram_rdata;
                        n_hole    = r_cur;
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lpht_pkg::S_RM_FIN: begin
                // hole at end of chain becomes empty
                ram_we    = 1'b1;
                ram_waddr = r_hole;
                if (r_count != '0) n_count = r_count - 1'b1;
            end
            lpht_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_pos  = pos_inc;
                if (r_pos == LAST_IDX) begin
                    n_count      = '0;
                    n_res_status = lpht_pkg::ST_OK;
                    n_res_found  = '0;
                end
            end
            lpht_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_found     = r_res_found;
                    n_entry     = r_count;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_INIT;
            r_pos       <= '0;
            r_count     <= '0;
            r_max       <= lpht_pkg::MAX_ENTRIES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_home       <= n_home;
        r_cnt        <= n_cnt;
        r_hole       <= n_hole;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_status     <= n_status;
        r_found      <= n_found;
        r_entry      <= n_entry;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_count = r_entry;

endmodule
`default_nettype wire

// ===== dv/linear_probe_hash_table_top_test.sv =====
// Self-checking testbench for the linear probing hash table top level.
`timescale 1ns / 1ps
module linear_probe_hash_table_top_test;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int KEY_W      = lpht_pkg::KEY_W;
    localparam int CFG_W      = lpht_pkg::CFG_W;
    localparam int HALF_CLK   = 5;
    localparam int END_DRAIN  = 300;
    localparam int MAX_REPORT = 10;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [lpht_pkg::CMD_W-1:0] i_command;
    logic [KEY_W-1:0]          i_key;
    logic [VALUE_BITS-1:0]     i_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [lpht_pkg::ST_W-1:0] o_status;
    logic [VALUE_BITS-1:0]     o_found_value;
    logic [CNT_W-1:0]          o_entry_count;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_W-1:0]          i_cfg_data;

    // Idle and stall odds, percent per cycle
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Keys that a phase draws from, so that hits and chains happen
    logic [KEY_W-1:0] key_pool[$];

    typedef struct packed {
        lpht_pkg::t_status     status;
        logic [VALUE_BITS-1:0] found;
        logic [CNT_W-1:0]      entries;
    } t_lpht_result;

    // Shadow copy of the table and the queue of results it predicts
    class lpht_shadow;
        bit                    used [CAPACITY];
        logic [KEY_W-1:0]      keys [CAPACITY];
        logic [VALUE_BITS-1:0] vals [CAPACITY];
        int unsigned           occupied;
        int unsigned           limit;
        int unsigned           mismatches;
        t_lpht_result          pending_results[$];

        function new();
            foreach (used[i]) used[i] = 1'b0;
            occupied   = 0;
            limit      = lpht_pkg::MAX_ENTRIES_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] lim);
            limit = lim;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Slot of the key, else first empty slot, else CAPACITY
        function int locate(logic [KEY_W-1:0] key, output bit hit);
            int pos;
            pos = int'(key % CAPACITY);
            hit = 1'b0;
            for (int n = 0; n < CAPACITY; n++) begin
                if (!used[pos]) return pos;
                if (keys[pos] == key) begin
                    hit = 1'b1;
                    return pos;
                end
                pos = (pos + 1) % CAPACITY;
            end
            return CAPACITY;
        endfunction

        // Backward-shift delete: later chain members fall back into the hole
        function void delete_at(int hole);
            int cur;
            int home;
            bit shift;
            cur = hole;
            for (int n = 0; n < CAPACITY; n++) begin
                cur = (cur + 1) % CAPACITY;
                if (!used[cur]) break;
                home = int'(keys[cur] % CAPACITY);
                if (cur > hole) shift = (home <= hole) || (home > cur);
                else shift = (home <= hole) && (home > cur);
                if (shift) begin
                    keys[hole] = keys[cur];
                    vals[hole] = vals[cur];
                    hole       = cur;
                end
            end
            used[hole] = 1'b0;
            if (occupied > 0) occupied--;
        endfunction

        // Apply one accepted command and queue its result
        function void note_command(lpht_pkg::t_cmd cmd, logic [KEY_W-1:0] key,
                                   logic [VALUE_BITS-1:0] value);
            t_lpht_result res;
            int           pos;
            bit           hit;
            int unsigned  eff_limit;
            res.status = lpht_pkg::ST_OK;
            res.found  = '0;
            eff_limit  = (limit < CAPACITY) ? limit : CAPACITY;
            case (cmd)
                lpht_pkg::CMD_FIND: begin
                    pos = locate(key, hit);
                    if (hit) res.found = vals[pos];
                    else res.status = lpht_pkg::ST_NOT_FOUND;
                end
                lpht_pkg::CMD_INSERT: begin
                    pos = locate(key, hit);
                    if (hit) begin
                        vals[pos] = value;
                    end else if (occupied >= eff_limit || pos >= CAPACITY) begin
                        res.status = lpht_pkg::ST_FULL;
                    end else begin
                        used[pos] = 1'b1;
                        keys[pos] = key;
                        vals[pos] = value;
                        occupied++;
                    end
                end
                lpht_pkg::CMD_REMOVE: begin
                    pos = locate(key, hit);
                    if (hit) delete_at(pos);
                    else res.status = lpht_pkg::ST_NOT_FOUND;
                end
                default: begin
                    foreach (used[i]) used[i] = 1'b0;
                    occupied = 0;
                end
            endcase
            res.entries = CNT_W'(occupied);
            pending_results.push_back(res);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(logic [lpht_pkg::ST_W-1:0] status,
                                   logic [VALUE_BITS-1:0] found,
                                   logic [CNT_W-1:0] entries);
            t_lpht_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: unexpected result status %0d value %h count %0d",
                             $realtime, status, found, entries);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || found !== want.found ||
                entries !== want.entries) begin
                mismatches++;
                if (mismatches <= MAX_REPORT) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  exp status %0d value %h count %0d",
                             want.status, want.found, want.entries);
                    $display("  got status %0d value %h count %0d",
                             status, found, entries);
                end
            end
        endfunction
    endclass

    lpht_shadow shadow = new();

    linear_probe_hash_table_top #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #HALF_CLK i_clk = ~i_clk;

    // Result side: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Result side: check every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(o_status, o_found_value, o_entry_count);
    end

    // Safety net against a hung block
    initial begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Present one command transaction and wait for its acceptance
    task automatic drive_command(lpht_pkg::t_cmd cmd, logic [KEY_W-1:0] key,
                                 logic [VALUE_BITS-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_key      = key;
        i_value    = value;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_command(cmd, key, value);
    endtask

    // Drop valid after the last transaction, then wait for all results
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (shadow.outstanding() != 0) @(posedge i_clk);
    endtask

    // Entry limit write; only called with nothing in flight
    task automatic write_limit(logic [CFG_W-1:0] lim);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_limit(lim);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    // Mix of full-width keys and keys crowded onto a few home slots
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        case ($urandom_range(3))
            0: ;
            1: k[5:0] = ($urandom_range(1)) ? 6'($urandom_range(1)) : 6'd62 + 6'($urandom_range(1));
            2: k = KEY_W'($urandom_range(200));
            default: k[5:0] = 6'($urandom_range(7)) << 3;
        endcase
        return k;
    endfunction

    function automatic logic [VALUE_BITS-1:0] make_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // One random phase at a given entry limit and idle mode
    task automatic run_phase(logic [CFG_W-1:0] lim, int mode, int n_items,
                             int ins_w, int fnd_w, int rem_w, int clr_w, int pool_n);
        lpht_pkg::t_cmd   cmd;
        logic [KEY_W-1:0] key;
        int               pick;
        wait_drained();
        write_limit(lim);
        set_idle_mode(mode);
        key_pool.delete();
        repeat (pool_n) key_pool.push_back(make_key());
        for (int i = 0; i < n_items; i++) begin
            // hold the sender until the block has answered everything
            if (i == n_items / 2) wait_drained();
            pick = $urandom_range(ins_w + fnd_w + rem_w + clr_w - 1);
            if (pick < ins_w) cmd = lpht_pkg::CMD_INSERT;
            else if (pick < ins_w + fnd_w) cmd = lpht_pkg::CMD_FIND;
            else if (pick < ins_w + fnd_w + rem_w) cmd = lpht_pkg::CMD_REMOVE;
            else cmd = lpht_pkg::CMD_CLEAR;
            if ($urandom_range(9) == 0) key = make_key();
            else key = key_pool[$urandom_range(key_pool.size() - 1)];
            drive_command(cmd, key, make_value());
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = lpht_pkg::CMD_FIND;
        i_key          = '0;
        i_value        = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, home collisions, wrap at the end, replace,
        // backward shift across the wrap, absent keys, clear
        drive_command(lpht_pkg::CMD_FIND,   31'd5,          32'h0);
        drive_command(lpht_pkg::CMD_REMOVE, 31'd5,          32'h0);
        drive_command(lpht_pkg::CMD_INSERT, 31'd0,          32'hFFFF_FFFF);
        drive_command(lpht_pkg::CMD_INSERT, 31'd64,         32'h0);
        drive_command(lpht_pkg::CMD_INSERT, 31'h7FFF_FFFF,  32'h5555_AAAA);
        drive_command(lpht_pkg::CMD_INSERT, 31'd127,        32'hAAAA_5555);
        drive_command(lpht_pkg::CMD_FIND,   31'd127,        32'hFFFF_FFFF);
        drive_command(lpht_pkg::CMD_FIND,   31'd64,         32'h0);
        drive_command(lpht_pkg::CMD_INSERT, 31'd0,          32'h1234_5678);
        drive_command(lpht_pkg::CMD_FIND,   31'd0,          32'h0);
        drive_command(lpht_pkg::CMD_REMOVE, 31'd0,          32'h0);
        drive_command(lpht_pkg::CMD_FIND,   31'd64,         32'h0);
        drive_command(lpht_pkg::CMD_FIND,   31'd127,        32'h0);
        drive_command(lpht_pkg::CMD_FIND,   31'd0,          32'h0);
        drive_command(lpht_pkg::CMD_REMOVE, 31'h7FFF_FFFF,  32'h0);
        drive_command(lpht_pkg::CMD_FIND,   31'd127,        32'h0);
        drive_command(lpht_pkg::CMD_CLEAR,  31'h7FFF_FFFF,  32'hFFFF_FFFF);
        drive_command(lpht_pkg::CMD_FIND,   31'd64,         32'h0);
        drive_command(lpht_pkg::CMD_FIND,   31'h4000_0040,  32'h0);
        drive_command(lpht_pkg::CMD_INSERT, 31'd9,          32'hDEAD_BEEF);

        // Limit zero: a present key is still replaced, a new key is refused
        wait_drained();
        write_limit(7'd0);
        drive_command(lpht_pkg::CMD_INSERT, 31'd9,          32'h0BAD_F00D);
        drive_command(lpht_pkg::CMD_INSERT, 31'd10,         32'h1);
        drive_command(lpht_pkg::CMD_FIND,   31'd9,          32'h0);

        // Limit one, at the limit, then room again after a remove
        wait_drained();
        write_limit(7'd1);
        drive_command(lpht_pkg::CMD_INSERT, 31'd10,         32'h2);
        drive_command(lpht_pkg::CMD_REMOVE, 31'd9,          32'h0);
        drive_command(lpht_pkg::CMD_INSERT, 31'd10,         32'h3);

        // Random phases; the first fills all slots so full probes happen
        run_phase(7'd127, 0, 160, 70, 25, 5, 0, 72);
        run_phase(7'd64,  1, 80, 40, 30, 25, 5, 40);
        run_phase(7'd1,   2, 60, 45, 30, 20, 5, 12);
        run_phase(7'd0,   3, 60, 45, 30, 20, 5, 12);
        run_phase(7'd48,  0, 80, 45, 30, 22, 3, 60);
        run_phase(CFG_W'($urandom_range(1, 64)),  1, 90, 45, 30, 22, 3, 50);
        run_phase(CFG_W'($urandom_range(0, 127)), 2, 90, 45, 30, 22, 3, 50);
        run_phase(7'd127, 3, 90, 55, 25, 20, 0, 70);

        // Let the block settle, then judge
        wait_drained();
        repeat (END_DRAIN) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
